[rtl/svdf_pkg.sv]
// Package: shared types, constants and helper functions for the digit frame block.
`timescale 1ns / 1ps
package svdf_pkg;

  // Frame layout and digit codes
  localparam int unsigned DEFAULT_DIGITS = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [3:0]  CMD_WRITE      = 4'h1;
  localparam logic [7:0]  CODE_MINUS     = 8'h0A;
  localparam logic [7:0]  CODE_BLANK     = 8'h0F;
  localparam int unsigned QUOT_W         = 12;   // 32768 / 10 fits in 12 bits

  // Input item
  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         offset;
  } svdf_in_t;

  // Result item
  typedef struct packed {
    logic [15:0] frame_word;
    logic        last;
  } svdf_out_t;

  // Classified item waiting in the queue
  typedef struct packed {
    logic [QUOT_W-1:0] quot;    // magnitude / 10
    logic [3:0]        offset;
    logic              neg;
  } svdf_entry_t;

  // Exact divide by ten for any 16-bit unsigned value (reciprocal multiply)
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = x * 32'd52429;
    return prod[31:19];
  endfunction

endpackage

[rtl/svdf_front.sv]
// Front end: accepts input items, takes magnitude and sign, and pushes them into the queue.
`timescale 1ns / 1ps
module svdf_front
  import svdf_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  svdf_in_t    in_item,
  input  logic        q_full,
  output logic        q_push,
  output svdf_entry_t q_data
);

  logic        neg;
  logic [15:0] mag;

  // Magnitude as unsigned; the most negative value maps to 32768
  always_comb begin
    neg = in_item.value[15];
    mag = neg ? (~in_item.value + 16'd1) : in_item.value;
  end

  // Push whenever the queue has room
  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full;
  assign q_data.quot    = QUOT_W'(div10(mag));
  assign q_data.offset  = in_item.offset;
  assign q_data.neg     = neg;

endmodule

[rtl/svdf_fifo.sv]
// Short queue between front and back end, held in flip-flops.
`timescale 1ns / 1ps
module svdf_fifo
  import svdf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  svdf_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output svdf_entry_t head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  svdf_entry_t        mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];

endmodule

[rtl/svdf_back.sv]
// Back end: steps one queued item's digits to an output register, one frame per cycle unless stalled.
`timescale 1ns / 1ps
module svdf_back
  import svdf_pkg::*;
#(
  parameter int unsigned DIGITS = DEFAULT_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  svdf_entry_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output svdf_out_t   out_item
);

  localparam int unsigned IDX_W = $clog2(DIGITS);

  logic              act_valid_r, act_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [QUOT_W-1:0] act_q_r, act_q_nxt;
  logic [3:0]        act_off_r, act_off_nxt;
  logic              act_neg_r, act_neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  svdf_out_t         out_item_r, out_item_nxt;

  logic              slot_free;
  logic              emit;
  logic              is_top;
  logic              finish;
  logic              load;
  logic [QUOT_W-1:0] q2;
  logic [QUOT_W-1:0] q2_x10;
  logic [QUOT_W-1:0] rem;
  logic [3:0]        addr;
  logic [7:0]        code;

  // Next quotient and the current digit: digit = q - 10 * (q / 10)
  always_comb begin
    q2     = QUOT_W'(div10(16'(act_q_r)));
    q2_x10 = QUOT_W'({q2, 3'b000}) + QUOT_W'({q2, 1'b0});
    rem    = act_q_r - q2_x10;
  end

  // Handshake and sequencing
  always_comb begin
    slot_free = !out_valid_r || out_ready;
    emit      = act_valid_r && slot_free;
    is_top    = (idx_r == IDX_W'(DIGITS - 1));
    finish    = emit && is_top;
    load      = (!act_valid_r || finish) && q_valid;
    addr      = act_off_r + 4'(idx_r) + 4'd1;
    code      = is_top ? (act_neg_r ? CODE_MINUS : CODE_BLANK) : {4'b0000, rem[3:0]};
  end

  // Working item and output register next values
  always_comb begin
    act_valid_nxt = act_valid_r;
    idx_nxt       = idx_r;
    act_q_nxt     = act_q_r;
    act_off_nxt   = act_off_r;
    act_neg_nxt   = act_neg_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.frame_word = {CMD_WRITE, addr, code};
      out_item_nxt.last       = is_top;
      if (!is_top) begin
        idx_nxt   = idx_r + IDX_W'(1);
        act_q_nxt = q2;
      end
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      act_valid_nxt = 1'b1;
      idx_nxt       = '0;
      act_q_nxt     = q_data.quot;
      act_off_nxt   = q_data.offset;
      act_neg_nxt   = q_data.neg;
    end else if (finish) begin
      act_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      act_valid_r <= act_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    act_q_r    <= act_q_nxt;
    act_off_r  <= act_off_nxt;
    act_neg_r  <= act_neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign q_pop     = load;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/signed_value_to_digit_frames.sv]
// An item passes the queue, then the working item register, then the output register.
// Throughput: one frame per cycle unless out_ready stalls, DIGITS_PER_VALUE frames per item
//   (4 by default), set by the back-end digit sequencer that emits one frame each cycle.
// A two-entry queue lets the front accept items while the back end is still emitting.
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer and drops out_valid.
`timescale 1ns / 1ps
module signed_value_to_digit_frames
  import svdf_pkg::*;
#(
  parameter int unsigned DIGITS_PER_VALUE = DEFAULT_DIGITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  svdf_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output svdf_out_t out_item
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  svdf_entry_t q_wdata;
  svdf_entry_t q_rdata;

  // Classify and enqueue
  svdf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Decoupling queue
  svdf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_rdata)
  );

  // Digit sequencer and output register
  svdf_back #(
    .DIGITS (DIGITS_PER_VALUE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[rtl/svdf_checker.sv]
// Port-level checks on the digit frame block, bound to the top level.
`timescale 1ns / 1ps
module svdf_checker
  import svdf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input svdf_out_t out_item
);

  // Output is empty right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled frame changed");

  // Every frame carries the write command
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.frame_word[15:12] == CMD_WRITE)
    else $error("bad command nibble");

  // The closing frame carries the sign code
  a_top_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |->
      out_item.frame_word[7:0] == CODE_MINUS || out_item.frame_word[7:0] == CODE_BLANK)
    else $error("bad sign code on last frame");

  // Lower frames carry a decimal digit
  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> out_item.frame_word[7:0] < 8'd10)
    else $error("digit out of range");

endmodule

bind signed_value_to_digit_frames svdf_checker u_svdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[tb/tb_top.sv]
// Self-checking testbench for signed_value_to_digit_frames with random flow control.
`timescale 1ns / 1ps
module tb_top
  import svdf_pkg::*;
();

  localparam int unsigned DIGITS = DEFAULT_DIGITS;
  localparam int unsigned RANDOM_VALUES = 260;

  // Value waiting to be sent; drain_first holds it back until all frames are out
  typedef struct packed {
    svdf_in_t item;
    logic     drain_first;
  } value_job_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  svdf_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  svdf_out_t out_item;

  value_job_t values_todo[$];
  svdf_out_t  frames_due[$];
  int         values_queued = 0;
  int         values_taken = 0;
  int         mismatches = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         quiet_left = 0;
  logic       quiet = 1'b0;

  signed_value_to_digit_frames #(
    .DIGITS_PER_VALUE(DIGITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Expected frames for one value: tens upward, then the sign frame
  function automatic void predict_digit_frames(input svdf_in_t it);
    logic [16:0] mag;
    logic [3:0]  addr;
    logic [7:0]  code;
    svdf_out_t   f;
    int          i;
    mag = it.value[15] ? (17'h10000 - {1'b0, it.value}) : {1'b0, it.value};
    for (i = 0; i < int'(DIGITS) - 1; i++) begin
      mag = mag / 10;
      addr = it.offset + 4'(i + 1);
      code = 8'(mag % 10);
      f.frame_word = {CMD_WRITE, addr, code};
      f.last = 1'b0;
      frames_due.push_back(f);
    end
    addr = it.offset + 4'(DIGITS);
    code = it.value[15] ? CODE_MINUS : CODE_BLANK;
    f.frame_word = {CMD_WRITE, addr, code};
    f.last = 1'b1;
    frames_due.push_back(f);
  endfunction

  task automatic queue_value(input logic [15:0] v, input logic [3:0] off,
                             input logic drain);
    value_job_t job;
    job.item.value = v;
    job.item.offset = off;
    job.drain_first = drain;
    values_todo.push_back(job);
    values_queued++;
  endtask

  // Stretches where neither side idles
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      quiet <= ($urandom_range(0, 3) == 0);
      quiet_left = $urandom_range(50, 300);
    end else begin
      quiet_left--;
    end
  end

  // Input driver
  always @(posedge clk) begin : drive_values
    logic       fire;
    logic       next_valid;
    value_job_t job;
    fire = in_valid && in_ready;
    next_valid = in_valid && !fire;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (values_todo.size() != 0 &&
                   !(values_todo[0].drain_first && (fire || frames_due.size() != 0))) begin
        job = values_todo.pop_front();
        in_item <= job.item;
        next_valid = 1'b1;
        gap_left = (!quiet && $urandom_range(0, 99) < 35) ? pick_idle() : 0;
      end
    end
    in_valid <= next_valid;
  end

  // Result sink with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      stall_left = pick_idle() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted value, check each accepted frame
  always @(posedge clk) begin : check_frames
    svdf_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_digit_frames(in_item);
        values_taken++;
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("frame with nothing expected", out_item, '0);
        end else begin
          want = frames_due.pop_front();
          if (out_item.frame_word !== want.frame_word)
            report_mismatch("frame_word", out_item.frame_word, want.frame_word);
          if (out_item.last !== want.last)
            report_mismatch("last", out_item.last, want.last);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          n;
    int          x;
    int          kind;
    int          w;
    logic        drain;
    int          decades[4];
    decades = '{10, 100, 1000, 10000};

    // Directed: extremes, decade edges, sign, address wrap
    queue_value(16'h0000, 4'd0, 1'b0);
    queue_value(16'h7FFF, 4'd15, 1'b0);
    queue_value(16'h8000, 4'd12, 1'b0);   // most negative, magnitude as unsigned
    queue_value(16'hFFFF, 4'd13, 1'b0);
    queue_value(16'h0001, 4'd14, 1'b0);
    queue_value(16'd9, 4'd1, 1'b0);
    queue_value(16'd10, 4'd2, 1'b0);
    queue_value(16'd99, 4'd3, 1'b0);
    queue_value(16'd100, 4'd4, 1'b0);
    queue_value(16'd999, 4'd5, 1'b0);
    queue_value(16'd1000, 4'd6, 1'b1);
    queue_value(16'd9999, 4'd7, 1'b0);
    queue_value(16'd10000, 4'd8, 1'b0);
    queue_value(16'hFFF6, 4'd9, 1'b0);     // -10
    queue_value(16'hD8F1, 4'd10, 1'b0);    // -9999
    queue_value(16'd12345, 4'd11, 1'b0);
    queue_value(16'hCFC7, 4'd15, 1'b0);    // -12345
    queue_value(16'h5555, 4'd5, 1'b0);
    queue_value(16'hAAAA, 4'd10, 1'b0);
    queue_value(16'h8001, 4'd0, 1'b0);
    queue_value(16'h7FFE, 4'd3, 1'b0);

    // Random: uniform, small, decade edges, near the extremes
    for (n = 0; n < int'(RANDOM_VALUES); n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        4, 5: begin
          x = int'($urandom_range(0, 2400)) - 1200;
        end
        6, 7: begin
          x = decades[$urandom_range(0, 3)] + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1) == 1) x = -x;
        end
        8: begin
          x = ($urandom_range(0, 1) == 1) ? 32767 - int'($urandom_range(0, 3))
                                          : -32768 + int'($urandom_range(0, 3));
        end
        default: begin
          x = int'($urandom);
        end
      endcase
      drain = (n == 0) || ($urandom_range(0, 99) < 3);
      queue_value(16'(x), 4'($urandom_range(0, 15)), drain);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (values_taken < values_queued) @(posedge clk);
    for (w = 0; w < 20000 && frames_due.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0)
      report_mismatch("frames never produced", frames_due.size(), 0);

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
